>>> rtl/periodic_down_counter_timer_defines.svh
// Assertion macros used by the timer top level.
`ifndef PERIODIC_DOWN_COUNTER_TIMER_DEFINES_SVH
`define PERIODIC_DOWN_COUNTER_TIMER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PDCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer check failed (same cycle)");

// Next-cycle implication, checked out of reset.
`define PDCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer check failed (next cycle)");

`endif

>>> rtl/pdct_pkg.sv
// Types and constants for the periodic down-counter timer.
package pdct_pkg;

  // Item kinds carried on the action field
  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_WR_CTRL   = 3'd1,
    ACT_WR_LOAD   = 3'd2,
    ACT_WR_STATUS = 3'd3,
    ACT_RD_CTRL   = 3'd4,
    ACT_RD_STATUS = 3'd5,
    ACT_RD_COUNT  = 3'd6,
    ACT_RD_LOAD   = 3'd7
  } pdct_action_t;

  localparam int unsigned DATA_W = 32;

  // Control word layout
  localparam int unsigned BIT_EN      = 0;
  localparam int unsigned BIT_ENMOD   = 1;
  localparam int unsigned BIT_OCIE    = 2;
  localparam int unsigned BIT_RLD     = 3;
  localparam int unsigned PRE_LSB     = 4;
  localparam int unsigned PRE_FIELD_W = 12;
  localparam int unsigned BIT_SWR     = 16;
  localparam int unsigned BIT_IOVW    = 17;
  localparam int unsigned BIT_WAITEN  = 19;
  localparam int unsigned BIT_STOPEN  = 21;
  localparam int unsigned CLK_LSB     = 24;
  localparam int unsigned CLK_W       = 2;

  // Status word: flag clear / flag read bit
  localparam int unsigned BIT_FLAG    = 0;

  typedef logic [CLK_W-1:0] pdct_clk_sel_t;

  typedef struct packed {
    pdct_action_t        action;
    logic [DATA_W-1:0]   write_data;
    logic                wait_mode;
    logic                stop_mode;
  } pdct_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic                compare_flag;
    logic                irq;
  } pdct_result_t;

endpackage

>>> rtl/pdct_core.sv
// Timer register bank, prescaler and counter: executes one item per cycle while item_fire is high.
module pdct_core #(
  parameter int unsigned COUNTER_BITS   = 32,
  parameter int unsigned PRESCALER_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [pdct_pkg::DATA_W-1:0]  cfg_wr_data,
  input  logic                         item_fire,
  input  pdct_pkg::pdct_item_t         item,
  output pdct_pkg::pdct_result_t       result
);
  import pdct_pkg::*;

  localparam logic [COUNTER_BITS-1:0] CNT_ONES = {COUNTER_BITS{1'b1}};

  logic                      en_r, en_nxt;
  logic                      enmod_r, enmod_nxt;
  logic                      ocie_r, ocie_nxt;
  logic                      rld_r, rld_nxt;
  logic [PRESCALER_BITS-1:0] pre_div_r, pre_div_nxt;
  logic                      iovw_r, iovw_nxt;
  logic                      waiten_r, waiten_nxt;
  logic                      stopen_r, stopen_nxt;
  pdct_clk_sel_t             clk_sel_r, clk_sel_nxt;
  logic [COUNTER_BITS-1:0]   reload_r, reload_nxt;
  logic [COUNTER_BITS-1:0]   count_r, count_nxt;
  logic [PRESCALER_BITS-1:0] pre_cnt_r, pre_cnt_nxt;
  logic                      flag_r, flag_nxt;
  logic [COUNTER_BITS-1:0]   cmp_r;

  logic [DATA_W-1:0]         ctrl_word;
  logic [COUNTER_BITS-1:0]   wr_cnt;
  logic                      tick_ok;
  logic [DATA_W-1:0]         rd_data;

  assign wr_cnt = item.write_data[COUNTER_BITS-1:0];

  // Counting is gated by the enable bit, the clock source and the low-power modes
  assign tick_ok = en_r && (clk_sel_r != '0)
                   && !(item.wait_mode && !waiten_r)
                   && !(item.stop_mode && !stopen_r);

  // Assemble the control word for read-back
  always_comb begin
    ctrl_word = '0;
    ctrl_word[BIT_EN]                   = en_r;
    ctrl_word[BIT_ENMOD]                = enmod_r;
    ctrl_word[BIT_OCIE]                 = ocie_r;
    ctrl_word[BIT_RLD]                  = rld_r;
    ctrl_word[PRE_LSB +: PRE_FIELD_W]   = PRE_FIELD_W'(pre_div_r);
    ctrl_word[BIT_IOVW]                 = iovw_r;
    ctrl_word[BIT_WAITEN]               = waiten_r;
    ctrl_word[BIT_STOPEN]               = stopen_r;
    ctrl_word[CLK_LSB +: CLK_W]         = clk_sel_r;
  end

  // Next state for the item in hand
  always_comb begin
    en_nxt      = en_r;
    enmod_nxt   = enmod_r;
    ocie_nxt    = ocie_r;
    rld_nxt     = rld_r;
    pre_div_nxt = pre_div_r;
    iovw_nxt    = iovw_r;
    waiten_nxt  = waiten_r;
    stopen_nxt  = stopen_r;
    clk_sel_nxt = clk_sel_r;
    reload_nxt  = reload_r;
    count_nxt   = count_r;
    pre_cnt_nxt = pre_cnt_r;
    flag_nxt    = flag_r;
    rd_data     = '0;
    case (item.action)
      ACT_TICK: begin
        if (tick_ok) begin
          if (pre_cnt_r != pre_div_r) begin
            pre_cnt_nxt = pre_cnt_r + PRESCALER_BITS'(1);
          end else begin
            pre_cnt_nxt = '0;
            if (count_r == '0) begin
              count_nxt = rld_r ? reload_r : CNT_ONES;
            end else begin
              count_nxt = count_r - COUNTER_BITS'(1);
            end
            if (count_nxt == cmp_r) begin
              flag_nxt = 1'b1;
            end
          end
        end
      end
      ACT_WR_CTRL: begin
        en_nxt     = item.write_data[BIT_EN];
        enmod_nxt  = item.write_data[BIT_ENMOD];
        waiten_nxt = item.write_data[BIT_WAITEN];
        stopen_nxt = item.write_data[BIT_STOPEN];
        if (item.write_data[BIT_SWR]) begin
          // Soft reset completes within this write
          ocie_nxt    = 1'b0;
          rld_nxt     = 1'b0;
          pre_div_nxt = '0;
          iovw_nxt    = 1'b0;
          clk_sel_nxt = '0;
          reload_nxt  = CNT_ONES;
          count_nxt   = CNT_ONES;
          pre_cnt_nxt = '0;
          flag_nxt    = 1'b0;
        end else begin
          ocie_nxt    = item.write_data[BIT_OCIE];
          rld_nxt     = item.write_data[BIT_RLD];
          pre_div_nxt = item.write_data[PRE_LSB +: PRESCALER_BITS];
          iovw_nxt    = item.write_data[BIT_IOVW];
          clk_sel_nxt = item.write_data[CLK_LSB +: CLK_W];
        end
        // Enable rising: restart prescaler, optionally the counter
        if (!en_r && en_nxt) begin
          pre_cnt_nxt = '0;
          if (enmod_nxt) begin
            count_nxt = rld_nxt ? reload_nxt : CNT_ONES;
          end
        end
      end
      ACT_WR_LOAD: begin
        reload_nxt = wr_cnt;
        if (iovw_r) begin
          count_nxt = wr_cnt;
        end
      end
      ACT_WR_STATUS: begin
        if (item.write_data[BIT_FLAG]) begin
          flag_nxt = 1'b0;
        end
      end
      ACT_RD_CTRL:   rd_data = ctrl_word;
      ACT_RD_STATUS: rd_data = DATA_W'(flag_r);
      ACT_RD_COUNT:  rd_data = DATA_W'(count_r);
      ACT_RD_LOAD:   rd_data = DATA_W'(reload_r);
      default:       rd_data = '0;
    endcase
  end

  assign result.read_data    = rd_data;
  assign result.compare_flag = flag_nxt;
  assign result.irq          = flag_nxt && ocie_nxt;

  // Commit state when the item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r      <= 1'b0;
      enmod_r   <= 1'b0;
      ocie_r    <= 1'b0;
      rld_r     <= 1'b0;
      pre_div_r <= '0;
      iovw_r    <= 1'b0;
      waiten_r  <= 1'b0;
      stopen_r  <= 1'b0;
      clk_sel_r <= '0;
      reload_r  <= CNT_ONES;
      count_r   <= CNT_ONES;
      pre_cnt_r <= '0;
      flag_r    <= 1'b0;
    end else if (item_fire) begin
      en_r      <= en_nxt;
      enmod_r   <= enmod_nxt;
      ocie_r    <= ocie_nxt;
      rld_r     <= rld_nxt;
      pre_div_r <= pre_div_nxt;
      iovw_r    <= iovw_nxt;
      waiten_r  <= waiten_nxt;
      stopen_r  <= stopen_nxt;
      clk_sel_r <= clk_sel_nxt;
      reload_r  <= reload_nxt;
      count_r   <= count_nxt;
      pre_cnt_r <= pre_cnt_nxt;
      flag_r    <= flag_nxt;
    end
  end

  // Compare register, written from the configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_r <= '0;
    end else if (cfg_wr_en) begin
      cmp_r <= cfg_wr_data[COUNTER_BITS-1:0];
    end
  end

endmodule

>>> rtl/periodic_down_counter_timer.sv
// Top level of the periodic down-counter timer: input and result registers around the core.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+--------------------------------------------
//   in_      | in        | in_valid/in_ready   | action, write_data, wait_mode, stop_mode
//   out_     | out       | out_valid/out_ready | read_data, compare_flag, irq
//   cfg_     | in        | cfg_wr_en           | cfg_wr_data (compare value)
//
// One item per cycle sustained while out_ready stays high; each item passes through the
// input register, then core logic into the result register, where out_valid rises and
// the result waits to be taken.
// A full result register stalled by out_ready holds the input register, which then
// drops in_ready; accepting continues in the same cycle that out_ready returns.
// Reset is synchronous, active low; no clearing pass is needed.
`include "periodic_down_counter_timer_defines.svh"

module periodic_down_counter_timer #(
  parameter int unsigned COUNTER_BITS   = 32,
  parameter int unsigned PRESCALER_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_action,
  input  logic [pdct_pkg::DATA_W-1:0]  in_write_data,
  input  logic                         in_wait_mode,
  input  logic                         in_stop_mode,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pdct_pkg::DATA_W-1:0]  out_read_data,
  output logic                         out_compare_flag,
  output logic                         out_irq,
  input  logic                         cfg_wr_en,
  input  logic [pdct_pkg::DATA_W-1:0]  cfg_wr_data
);
  import pdct_pkg::*;

  logic          s1_valid_r;
  pdct_item_t    s1_item_r;
  logic          advance;
  pdct_result_t  core_res;
  pdct_result_t  res_r;
  logic          out_valid_r;

  // Input register moves on whenever the result register can take its item
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Capture the item payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.action     <= pdct_action_t'(in_action);
      s1_item_r.write_data <= in_write_data;
      s1_item_r.wait_mode  <= in_wait_mode;
      s1_item_r.stop_mode  <= in_stop_mode;
    end
  end

  pdct_core #(
    .COUNTER_BITS   (COUNTER_BITS),
    .PRESCALER_BITS (PRESCALER_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_fire   (advance),
    .item        (s1_item_r),
    .result      (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= core_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = res_r.read_data;
  assign out_compare_flag = res_r.compare_flag;
  assign out_irq          = res_r.irq;

  // Checks
  `PDCT_ASSERT_NOW(a_irq_needs_flag, clk, rst_n, out_valid, !out_irq || out_compare_flag)
  `PDCT_ASSERT_NOW(a_stall_blocks_input, clk, rst_n, s1_valid_r && out_valid_r && !out_ready, !in_ready)
  `PDCT_ASSERT_NEXT(a_held_item_stays, clk, rst_n, s1_valid_r && !advance, s1_valid_r)
  `PDCT_ASSERT_NEXT(a_status_clear, clk, rst_n, advance && (s1_item_r.action == ACT_WR_STATUS) && s1_item_r.write_data[BIT_FLAG], out_valid && !out_compare_flag)

endmodule
